/* design/pdlr_pkg.sv */
`default_nettype none

package pdlr_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int SAMPLE_W    = 32;
    localparam int COUNT_W     = 24;
    localparam int MAX_RESULTS = 64;
    localparam int NRES_W      = 7;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_CHANNELS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_CHANNELS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OUT_FRAMES  = 3'd4;

    localparam logic [2:0] FMT_PCM8    = 3'd0;
    localparam logic [2:0] FMT_PCM16   = 3'd1;
    localparam logic [2:0] FMT_PCM24   = 3'd2;
    localparam logic [2:0] FMT_PCM32   = 3'd3;
    localparam logic [2:0] FMT_FLOAT32 = 3'd4;

    localparam logic [1:0] CHAN_MONO   = 2'd1;
    localparam logic [1:0] CHAN_STEREO = 2'd2;

    localparam logic [SAMPLE_W-1:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [SAMPLE_W-1:0] POS_FULL = 32'h7FFF_FFFF;

    function automatic logic [SAMPLE_W-1:0] float_decode(input logic [SAMPLE_W-1:0] u);
        logic [7:0]          e;
        logic [23:0]         m;
        logic                neg;
        logic [SAMPLE_W-1:0] mag;
        logic [7:0]          sh;
        e   = u[30:23];
        m   = {1'b1, u[22:0]};
        neg = u[31];
        mag = '0;
        sh  = 8'd119 - e;
        if (e >= 8'd119) begin
            mag = 32'(m) << (e - 8'd119);
        end else if (sh < 8'd24) begin
            mag = 32'(m >> sh[4:0]);
        end
        if (e == 8'hFF) begin
            if (u[22:0] != 23'd0) begin
                float_decode = '0;
            end else begin
                float_decode = neg ? SIGN_BIT : POS_FULL;
            end
        end else if (e == 8'd0) begin
            float_decode = '0;
        end else if (e >= 8'd127) begin
            float_decode = neg ? SIGN_BIT : POS_FULL;
        end else begin
            float_decode = neg ? (32'd0 - mag) : mag;
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] pcm_decode(input logic [2:0] fmt,
                                                     input logic [SAMPLE_W-1:0] raw);
        case (fmt)
            FMT_PCM8:    pcm_decode = {raw[7:0] ^ 8'h80, 24'd0};
            FMT_PCM16:   pcm_decode = {raw[15:0], 16'd0};
            FMT_PCM24:   pcm_decode = {raw[23:0], 8'd0};
            FMT_PCM32:   pcm_decode = raw;
            FMT_FLOAT32: pcm_decode = float_decode(raw);
            default:     pcm_decode = '0;
        endcase
    endfunction

    // biased input, round half up, saturate high
    function automatic logic signed [15:0] to_i16(input logic [SAMPLE_W:0] biased,
                                                  input logic mono);
        logic [SAMPLE_W+1:0] sum;
        logic [17:0]         v;
        sum = mono ? (34'(biased) + 34'h1_0000) : (34'(biased) + 34'h8000);
        v   = mono ? 18'(sum >> 17) : 18'(sum >> 16);
        if (v > 18'h0FFFF) begin
            v = 18'h0FFFF;
        end
        to_i16 = $signed({~v[15], v[14:0]});
    endfunction

endpackage

`default_nettype wire

/* design/pcm_decode_linear_resampler.sv */
`default_nettype none

// Decodes one raw PCM or float32 source frame per input beat and produces the output
// frames that fall before it by linear interpolation, one multiplier shared by both
// channels. A source frame goes through decode and bookkeeping states, one more closing
// check for each pass it runs (the interpolation pass when a previous frame is held, the
// last-frame pass on the last frame of a clip), plus a check, two multiplies, a mix and an
// emit for each interpolated output, and a check and an emit for each output made from
// the last frame of a clip; o_in_ready is low for that whole time.
// Results pass through a one-deep hold and an output register, so a stalled consumer only
// stops the sequencer once both are full. Configuration is taken at any time
// and must only change between clips or while idle.
module pcm_decode_linear_resampler #(
    parameter int OUT_INDEX_BITS  = 24,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,

    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [pdlr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [pdlr_pkg::CFG_DATA_W-1:0]    i_cfg_data,

    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire  [pdlr_pkg::SAMPLE_W-1:0]      i_left_raw,
    input  wire  [pdlr_pkg::SAMPLE_W-1:0]      i_right_raw,
    input  wire                                i_last_frame,

    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic signed [15:0]                 o_left_out,
    output logic signed [15:0]                 o_right_out,
    output logic [OUT_INDEX_BITS-1:0]          o_out_index,
    output logic                               o_run_last,
    output logic                               o_clip_done
);
    import pdlr_pkg::*;

    localparam int POS_W  = 32 + PHASE_FRAC_BITS;
    localparam int END_W  = 33 + PHASE_FRAC_BITS;
    localparam int PROD_W = 34 + PHASE_FRAC_BITS;
    localparam logic [31:0] MIN_STEP = 32'((1 << PHASE_FRAC_BITS) / MAX_RESULTS);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC_L, S_DEC_R, S_CHECK, S_MUL_L, S_MUL_R, S_MIX_R, S_EMIT, S_FINISH
    } t_state;

    t_state r_state;

    logic [2:0]   r_fmt;
    logic [1:0]   r_src_ch;
    logic [1:0]   r_dst_ch;
    logic [31:0]  r_step_cfg;
    logic [COUNT_W-1:0] r_max;

    logic [SAMPLE_W-1:0] r_raw_l, r_raw_r;
    logic                r_last;
    logic [SAMPLE_W-1:0] r_cur_l, r_cur_r;
    logic [SAMPLE_W-1:0] r_prev_l, r_prev_r;
    logic                r_have_prev;
    logic [31:0]         r_src_idx;
    logic [POS_W-1:0]    r_pos;
    logic [COUNT_W-1:0]  r_count;
    logic [NRES_W-1:0]   r_nres;
    logic                r_phase2;

    logic signed [PROD_W-1:0] r_prod;
    logic [SAMPLE_W-1:0] r_mix_l, r_mix_r;

    logic                r_hold_v;
    logic signed [15:0]  r_hold_l, r_hold_r;
    logic [COUNT_W-1:0]  r_hold_idx;
    logic                r_hold_clip;

    logic                r_out_v;
    logic signed [15:0]  r_out_l, r_out_r;
    logic [COUNT_W-1:0]  r_out_idx;
    logic                r_out_run_last;
    logic                r_out_clip;

    logic [31:0]          step;
    logic [SAMPLE_W-1:0]  dec_out;
    logic [END_W-1:0]     end_pos, pos_ext;
    logic                 more;
    logic signed [32:0]   mul_a;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] mix_sum;
    logic [SAMPLE_W-1:0]  mix_base;
    logic                 out_free;
    logic                 load_out;
    logic                 dst_mono;
    logic signed [15:0]   n_l, n_r;
    logic [31:0]          idx_wide;

    assign step     = (r_step_cfg < MIN_STEP) ? MIN_STEP : r_step_cfg;
    assign dec_out  = pcm_decode(r_fmt, (r_state == S_DEC_R) ? r_raw_r : r_raw_l);
    assign pos_ext  = {1'b0, r_pos};
    assign end_pos  = r_phase2 ? {33'(r_src_idx) + 33'd1, {PHASE_FRAC_BITS{1'b0}}}
                               : {1'b0, r_src_idx, {PHASE_FRAC_BITS{1'b0}}};
    assign more     = (r_nres < NRES_W'(MAX_RESULTS)) && (r_count < r_max)
                      && (pos_ext < end_pos) && (!r_phase2 || r_last);

    // shared multiplier: (b - a) * frac, one channel per cycle
    assign mul_a    = (r_state == S_MUL_R)
                      ? $signed({1'b0, r_cur_r ^ SIGN_BIT}) - $signed({1'b0, r_prev_r ^ SIGN_BIT})
                      : $signed({1'b0, r_cur_l ^ SIGN_BIT}) - $signed({1'b0, r_prev_l ^ SIGN_BIT});
    assign mul_p    = PROD_W'(mul_a * $signed({1'b0, r_pos[PHASE_FRAC_BITS-1:0]}));
    assign mix_base = (r_state == S_MUL_R) ? (r_prev_l ^ SIGN_BIT) : (r_prev_r ^ SIGN_BIT);
    assign mix_sum  = $signed({{(PHASE_FRAC_BITS+2){1'b0}}, mix_base})
                      + (r_prod >>> PHASE_FRAC_BITS);

    assign dst_mono = (r_dst_ch == CHAN_MONO);
    assign n_l      = dst_mono ? to_i16(33'(r_mix_l) + 33'(r_mix_r), 1'b1)
                               : to_i16(33'(r_mix_l), 1'b0);
    assign n_r      = dst_mono ? 16'sd0 : to_i16(33'(r_mix_r), 1'b0);
    assign out_free = !r_out_v || i_out_ready;
    assign load_out = r_hold_v && out_free && ((r_state == S_EMIT) || (r_state == S_FINISH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fmt       <= FMT_PCM16;
            r_src_ch    <= CHAN_STEREO;
            r_dst_ch    <= CHAN_STEREO;
            r_step_cfg  <= 32'd65536;
            r_max       <= '1;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_have_prev <= 1'b0;
            r_src_idx   <= '0;
            r_pos       <= '0;
            r_count     <= '0;
            r_nres      <= '0;
            r_phase2    <= 1'b0;
            r_hold_v    <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_SAMPLE_FORMAT:   r_fmt      <= i_cfg_data[2:0];
                    REG_SOURCE_CHANNELS: r_src_ch   <= i_cfg_data[1:0];
                    REG_DEST_CHANNELS:   r_dst_ch   <= i_cfg_data[1:0];
                    REG_PHASE_STEP:      r_step_cfg <= i_cfg_data;
                    REG_MAX_OUT_FRAMES:  r_max      <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_raw_l <= i_left_raw;
                        r_raw_r <= i_right_raw;
                        r_last  <= i_last_frame;
                        r_nres  <= '0;
                        r_state <= S_DEC_L;
                    end
                end
                S_DEC_L: begin
                    r_cur_l <= dec_out;
                    r_state <= S_DEC_R;
                end
                S_DEC_R: begin
                    r_cur_r <= (r_src_ch == CHAN_MONO) ? r_cur_l : dec_out;
                    if (r_have_prev) begin
                        r_phase2 <= 1'b0;
                        r_state  <= S_CHECK;
                    end else if (r_last) begin
                        r_phase2 <= 1'b1;
                        r_state  <= S_CHECK;
                    end else begin
                        r_state  <= S_FINISH;
                    end
                end
                S_CHECK: begin
                    if (more) begin
                        if (r_phase2) begin
                            r_mix_l <= r_cur_l ^ SIGN_BIT;
                            r_mix_r <= r_cur_r ^ SIGN_BIT;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_MUL_L;
                        end
                    end else if (!r_phase2 && r_last) begin
                        r_phase2 <= 1'b1;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_MUL_L: begin
                    r_prod  <= mul_p;
                    r_state <= S_MUL_R;
                end
                S_MUL_R: begin
                    r_mix_l <= mix_sum[SAMPLE_W-1:0];
                    r_prod  <= mul_p;
                    r_state <= S_MIX_R;
                end
                S_MIX_R: begin
                    r_mix_r <= mix_sum[SAMPLE_W-1:0];
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_hold_v || out_free) begin
                        if (r_hold_v) begin
                            r_out_l        <= r_hold_l;
                            r_out_r        <= r_hold_r;
                            r_out_idx      <= r_hold_idx;
                            r_out_run_last <= 1'b0;
                            r_out_clip     <= r_hold_clip;
                        end
                        r_hold_v    <= 1'b1;
                        r_hold_l    <= n_l;
                        r_hold_r    <= n_r;
                        r_hold_idx  <= r_count;
                        r_hold_clip <= ((COUNT_W + 1)'(r_count) + (COUNT_W + 1)'(1))
                                       >= (COUNT_W + 1)'(r_max);
                        r_count     <= r_count + COUNT_W'(1);
                        r_pos       <= r_pos + POS_W'(step);
                        r_nres      <= r_nres + NRES_W'(1);
                        r_state     <= S_CHECK;
                    end
                end
                S_FINISH: begin
                    if (!r_hold_v || out_free) begin
                        if (r_hold_v) begin
                            r_out_l        <= r_hold_l;
                            r_out_r        <= r_hold_r;
                            r_out_idx      <= r_hold_idx;
                            r_out_run_last <= 1'b1;
                            r_out_clip     <= r_hold_clip || r_last;
                        end
                        r_hold_v <= 1'b0;
                        r_prev_l <= r_cur_l;
                        r_prev_r <= r_cur_r;
                        if (r_last) begin
                            r_have_prev <= 1'b0;
                            r_src_idx   <= '0;
                            r_pos       <= '0;
                            r_count     <= '0;
                        end else begin
                            r_have_prev <= 1'b1;
                            r_src_idx   <= r_src_idx + 32'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign idx_wide    = 32'(r_out_idx);
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_left_out  = r_out_l;
    assign o_right_out = r_out_r;
    assign o_out_index = idx_wide[OUT_INDEX_BITS-1:0];
    assign o_run_last  = r_out_run_last;
    assign o_clip_done = r_out_clip;

endmodule

`default_nettype wire
